// ----- rtl/i2c_sensor_register_slave_defines.svh -----
// Assertion macros shared by the sensor register slave RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef I2C_SENSOR_REGISTER_SLAVE_DEFINES_SVH
`define I2C_SENSOR_REGISTER_SLAVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/isrs_pkg.sv -----
// Types and constants for the sensor register slave.
// No dependencies; imported by isrs_echo and the top level.
`default_nettype none

package isrs_pkg;

  // Request kinds
  localparam logic [2:0] KIND_WR_START = 3'd0;
  localparam logic [2:0] KIND_WR_BYTE  = 3'd1;
  localparam logic [2:0] KIND_RD_BYTE  = 3'd2;
  localparam logic [2:0] KIND_STOP     = 3'd3;
  localparam logic [2:0] KIND_BUS_ERR  = 3'd4;
  localparam logic [2:0] KIND_ECHO     = 3'd5;
  localparam logic [2:0] KIND_ADC      = 3'd6;

  // Register map
  localparam logic [7:0] REG_NONE       = 8'h00;
  localparam logic [7:0] REG_LEFT_MSB   = 8'h01;
  localparam logic [7:0] REG_LEFT_LSB   = 8'h02;
  localparam logic [7:0] REG_RIGHT_MSB  = 8'h03;
  localparam logic [7:0] REG_RIGHT_LSB  = 8'h04;
  localparam logic [7:0] REG_FWD1_MSB   = 8'h05;
  localparam logic [7:0] REG_FWD1_LSB   = 8'h06;
  localparam logic [7:0] REG_BACK_MSB   = 8'h07;
  localparam logic [7:0] REG_BACK_LSB   = 8'h08;
  localparam logic [7:0] REG_VOLT_MSB   = 8'h09;
  localparam logic [7:0] REG_VOLT_LSB   = 8'h0A;
  localparam logic [7:0] REG_FWD2_MSB   = 8'h0B;
  localparam logic [7:0] REG_FWD2_LSB   = 8'h0C;
  localparam logic [7:0] REG_FWD1A_MSB  = 8'h15;
  localparam logic [7:0] REG_FWD1A_LSB  = 8'h16;
  localparam logic [7:0] REG_BACKA_MSB  = 8'h17;
  localparam logic [7:0] REG_BACKA_LSB  = 8'h18;
  localparam logic [7:0] REG_FWD2A_MSB  = 8'h19;
  localparam logic [7:0] REG_FWD2A_LSB  = 8'h1A;
  localparam logic [7:0] REG_BOOT       = 8'hFF;
  localparam logic [7:0] BOOT_MAGIC     = 8'hA5;

  // Echo channels and ADC channels
  localparam logic [1:0] ECHO_FWD1  = 2'd0;
  localparam logic [1:0] ECHO_BACK  = 2'd1;
  localparam logic [1:0] ECHO_FWD2  = 2'd2;
  localparam logic [1:0] ADC_LEFT   = 2'd0;
  localparam logic [1:0] ADC_RIGHT  = 2'd1;
  localparam logic [1:0] ADC_VOLT   = 2'd2;
  localparam logic [1:0] CHAN_NONE  = 2'd3;  // no echo timer or ADC input behind it

  // Trigger codes on the result
  localparam logic [1:0] TRIG_NONE = 2'd0;
  localparam logic [1:0] TRIG_FWD1 = 2'd1;
  localparam logic [1:0] TRIG_BACK = 2'd2;
  localparam logic [1:0] TRIG_FWD2 = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MM_PER_TICK = 2'd0;
  localparam logic [1:0] CFG_VOLT_GAIN   = 2'd1;

  localparam logic [15:0] MM_PER_TICK_RST = 16'd45197;
  localparam logic [9:0]  VOLT_GAIN_RST   = 10'd374;

  localparam int NUM_DIST  = 5;
  localparam int DIST_ECHO0 = 2;  // first echo slot in the distance table

  // Control from the register file to the echo timers
  typedef struct packed {
    logic        arm;     // select of an echo register
    logic        sample;  // echo pin sample on a valid channel
    logic [1:0]  ch;
    logic        level;
    logic [15:0] timer;
  } echo_ctl_t;

  // Distance update from the echo timers
  typedef struct packed {
    logic        en;
    logic [1:0]  ch;
    logic [15:0] mm;
  } echo_wr_t;

endpackage

`default_nettype wire

// ----- rtl/isrs_echo.sv -----
// Three echo pulse timers with millimetre scaling.
// Depends on isrs_pkg and i2c_sensor_register_slave_defines.svh.
`default_nettype none
`include "i2c_sensor_register_slave_defines.svh"

module isrs_echo
  import isrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire echo_ctl_t   ctl,
  input  wire logic [15:0] mm_per_tick,
  output echo_wr_t         wr
);

  logic [2:0]  armed_r;
  logic [2:0]  prev_r;
  logic [15:0] start_r [0:2];

  logic        sel_armed;
  logic        sel_prev;
  logic [15:0] sel_start;
  logic        edge_seen;
  logic        rise;
  logic        fall;
  logic [15:0] diff;
  logic [31:0] prod;
  logic [32:0] rounded;
  logic [18:0] mm_wide;

  always_comb begin
    unique case (ctl.ch)
      ECHO_FWD1: begin
        sel_armed = armed_r[0];
        sel_prev  = prev_r[0];
        sel_start = start_r[0];
      end
      ECHO_BACK: begin
        sel_armed = armed_r[1];
        sel_prev  = prev_r[1];
        sel_start = start_r[1];
      end
      ECHO_FWD2: begin
        sel_armed = armed_r[2];
        sel_prev  = prev_r[2];
        sel_start = start_r[2];
      end
      default: begin
        sel_armed = 1'b0;
        sel_prev  = 1'b0;
        sel_start = 16'd0;
      end
    endcase
  end

  assign edge_seen = ctl.sample && sel_armed && (ctl.level != sel_prev);
  assign rise      = edge_seen && ctl.level;
  assign fall      = edge_seen && !ctl.level;

  // Pulse width times Q2.14 scale, round half up, saturate to 16 bits
  assign diff    = ctl.timer - sel_start;
  assign prod    = {16'd0, diff} * {16'd0, mm_per_tick};
  assign rounded = {1'b0, prod} + 33'd8192;
  assign mm_wide = rounded[32:14];

  assign wr.en = fall;
  assign wr.ch = ctl.ch;
  assign wr.mm = (|mm_wide[18:16]) ? 16'hFFFF : mm_wide[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 3'd0;
      prev_r  <= 3'd0;
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= 16'd0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (ctl.ch == 2'(i)) begin
          if (ctl.arm) begin
            armed_r[i] <= 1'b1;
            prev_r[i]  <= 1'b0;
          end else if (ctl.sample) begin
            prev_r[i] <= ctl.level;
            if (rise) begin
              start_r[i] <= ctl.timer;
            end
            if (fall) begin
              armed_r[i] <= 1'b0;
            end
          end
        end
      end
    end
  end

  `ISRS_ASSERT_NOW(a_arm_xor_sample, ctl.arm, !ctl.sample, "arm and sample together")
  `ISRS_ASSERT_NOW(a_wr_on_valid_ch, wr.en, ctl.ch != CHAN_NONE, "distance write on bad channel")
  `ISRS_ASSERT_NEXT(a_fall_disarms, wr.en,
    $countones(armed_r) == $past($countones(armed_r)) - 1, "falling edge left channel armed")

endmodule

`default_nettype wire

// ----- rtl/i2c_sensor_register_slave.sv -----
// Top level of the I2C sensor register slave: request register, register file,
// result register. Depends on isrs_pkg, isrs_echo and the defines header.
//
// Usage
//   Requests enter on in_valid/in_ready: a bus event from the byte-level I2C
//   engine (write start, write byte, read byte, stop, bus error), an echo pin
//   sample with its timer count, or an averaged ADC result. Every request
//   gives exactly one result on out_valid/out_ready: read byte, ack, bus
//   reset, trigger strobe and reboot request. Non-bus requests give all zero.
//   The cfg_ channel writes mm_per_tick_q14 (index 0) and voltage_gain_q8
//   (index 1); cfg_ready is always high. Write configuration while idle.
// Timing
//   out_valid comes from the result register: an accepted request is held in
//   the request register while the register file, echo timer and its 16x16
//   multiply resolve into the result register. One request is taken per
//   cycle when the receiver keeps out_ready high.
// Reset and stall
//   rst_n (synchronous, active low) clears pointer, latched word, distances,
//   voltage, echo timers, boot byte and both pipeline valids, and loads the
//   default scale factors. While out_ready is low the result holds, one more
//   request is buffered in the request register, then in_ready drops.
`default_nettype none
`include "i2c_sensor_register_slave_defines.svh"

module i2c_sensor_register_slave
  import isrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [1:0]  in_channel,
  input  wire logic        in_pin_level,
  input  wire logic [15:0] in_timer_value,
  input  wire logic [9:0]  in_adc_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data,
  output logic             out_ack,
  output logic             out_bus_reset,
  output logic [1:0]       out_trigger_channel,
  output logic             out_reboot_request,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Request register
  logic        in_vld_r;
  logic [2:0]  kind_r;
  logic [7:0]  data_r;
  logic [1:0]  chan_r;
  logic        level_r;
  logic [15:0] timer_r;
  logic [9:0]  adc_r;

  // Result register
  logic        out_vld_r;
  logic [7:0]  rd_r;
  logic        ack_r;
  logic        brst_r;
  logic [1:0]  trig_r;
  logic        reboot_r;

  // Configuration
  logic [15:0] mm_per_tick_r;
  logic [9:0]  volt_gain_r;

  // Register file state
  logic [7:0]  ptr_r;
  logic [15:0] latched_r;
  logic [15:0] dist_r [0:NUM_DIST-1];
  logic [15:0] volt_r;
  logic [7:0]  boot_r;

  logic        take_in;
  logic        proc;
  logic        out_free;

  // Result and state next values
  logic [7:0]  rd_nxt;
  logic        ack_nxt;
  logic        brst_nxt;
  logic [1:0]  trig_nxt;
  logic        reboot_nxt;
  logic [7:0]  ptr_nxt;
  logic        latch_en;
  logic [15:0] latched_nxt;
  logic        boot_en;

  // Read map
  logic        map_hit;
  logic        map_msb;
  logic [15:0] map_val;

  // Echo arm / distance writes
  logic        arm_en;
  logic [1:0]  arm_ch;
  echo_ctl_t   echo_ctl;
  echo_wr_t    echo_wr;
  logic [19:0] volt_prod;

  // Handshake: advance the result when it is empty or taken
  assign out_free = !out_vld_r || out_ready;
  assign proc     = in_vld_r && out_free;
  assign in_ready = !in_vld_r || out_free;
  assign take_in  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take_in) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      kind_r  <= in_kind;
      data_r  <= in_data_byte;
      chan_r  <= in_channel;
      level_r <= in_pin_level;
      timer_r <= in_timer_value;
      adc_r   <= in_adc_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_per_tick_r <= MM_PER_TICK_RST;
      volt_gain_r   <= VOLT_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MM_PER_TICK) begin
        mm_per_tick_r <= cfg_data;
      end else if (cfg_index == CFG_VOLT_GAIN) begin
        volt_gain_r <= cfg_data[9:0];
      end
    end
  end

  // Decode the pointer for reads: MSB addresses latch a word, LSB return it
  always_comb begin
    map_hit = 1'b1;
    map_msb = 1'b0;
    map_val = 16'd0;
    unique case (ptr_r)
      REG_LEFT_MSB: begin
        map_msb = 1'b1;
        map_val = dist_r[0];
      end
      REG_RIGHT_MSB: begin
        map_msb = 1'b1;
        map_val = dist_r[1];
      end
      REG_FWD1_MSB, REG_FWD1A_MSB: begin
        map_msb = 1'b1;
        map_val = dist_r[2];
      end
      REG_BACK_MSB, REG_BACKA_MSB: begin
        map_msb = 1'b1;
        map_val = dist_r[3];
      end
      REG_VOLT_MSB: begin
        map_msb = 1'b1;
        map_val = volt_r;
      end
      REG_FWD2_MSB, REG_FWD2A_MSB: begin
        map_msb = 1'b1;
        map_val = dist_r[4];
      end
      REG_LEFT_LSB, REG_RIGHT_LSB, REG_FWD1_LSB, REG_BACK_LSB, REG_VOLT_LSB,
      REG_FWD2_LSB, REG_FWD1A_LSB, REG_BACKA_LSB, REG_FWD2A_LSB: begin
        map_hit = 1'b1;
      end
      default: begin
        map_hit = 1'b0;
      end
    endcase
  end

  // One request through the register file
  always_comb begin
    rd_nxt      = 8'd0;
    ack_nxt     = 1'b0;
    brst_nxt    = 1'b0;
    trig_nxt    = TRIG_NONE;
    reboot_nxt  = 1'b0;
    ptr_nxt     = ptr_r;
    latch_en    = 1'b0;
    latched_nxt = map_val;
    boot_en     = 1'b0;
    arm_en      = 1'b0;
    arm_ch      = ECHO_FWD1;
    unique case (kind_r)
      KIND_WR_START: begin
        ptr_nxt = REG_NONE;
        ack_nxt = 1'b1;
      end
      KIND_WR_BYTE: begin
        if (ptr_r == REG_NONE) begin
          // Register select; the FWD1, BACK and FWD2 MSB registers fire their trigger
          ptr_nxt = data_r;
          ack_nxt = 1'b1;
          if (data_r == REG_FWD1_MSB) begin
            arm_en   = 1'b1;
            arm_ch   = ECHO_FWD1;
            trig_nxt = TRIG_FWD1;
          end else if (data_r == REG_BACK_MSB) begin
            arm_en   = 1'b1;
            arm_ch   = ECHO_BACK;
            trig_nxt = TRIG_BACK;
          end else if (data_r == REG_FWD2_MSB) begin
            arm_en   = 1'b1;
            arm_ch   = ECHO_FWD2;
            trig_nxt = TRIG_FWD2;
          end
        end else begin
          // Data writes are refused; only the boot register stores
          ptr_nxt = ptr_r + 8'd1;
          if (ptr_r == REG_BOOT) begin
            boot_en    = 1'b1;
            reboot_nxt = (data_r == BOOT_MAGIC);
          end
        end
      end
      KIND_RD_BYTE: begin
        ptr_nxt = ptr_r + 8'd1;
        ack_nxt = map_hit;
        if (map_hit && map_msb) begin
          latch_en = 1'b1;
          rd_nxt   = map_val[15:8];
        end else if (map_hit) begin
          rd_nxt = latched_r[7:0];
        end
      end
      KIND_STOP: begin
        ack_nxt = 1'b1;
      end
      KIND_BUS_ERR: begin
        brst_nxt = 1'b1;
        ack_nxt  = 1'b1;
      end
      default: begin
        // echo, ADC and unused kinds return an all-zero result
      end
    endcase
  end

  assign echo_ctl.arm    = proc && arm_en;
  assign echo_ctl.sample = proc && (kind_r == KIND_ECHO) && (chan_r != CHAN_NONE);
  assign echo_ctl.ch     = arm_en ? arm_ch : chan_r;
  assign echo_ctl.level  = level_r;
  assign echo_ctl.timer  = timer_r;

  isrs_echo u_echo (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (echo_ctl),
    .mm_per_tick (mm_per_tick_r),
    .wr          (echo_wr)
  );

  assign volt_prod = {10'd0, adc_r} * {10'd0, volt_gain_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= REG_NONE;
      latched_r <= 16'd0;
      volt_r    <= 16'd0;
      boot_r    <= 8'd0;
      for (int i = 0; i < NUM_DIST; i++) begin
        dist_r[i] <= 16'd0;
      end
    end else if (proc) begin
      ptr_r <= ptr_nxt;
      if (latch_en) begin
        latched_r <= latched_nxt;
      end
      if (boot_en) begin
        boot_r <= data_r;
      end
      // Arm clears the distance; echo and ADC write new values
      for (int i = 0; i < NUM_DIST; i++) begin
        if (arm_en && (3'(i) == 3'(DIST_ECHO0) + {1'b0, arm_ch})) begin
          dist_r[i] <= 16'd0;
        end else if (echo_wr.en && (3'(i) == 3'(DIST_ECHO0) + {1'b0, echo_wr.ch})) begin
          dist_r[i] <= echo_wr.mm;
        end
      end
      if (kind_r == KIND_ADC) begin
        if (chan_r == ADC_LEFT) begin
          dist_r[0] <= {6'd0, adc_r};
        end else if (chan_r == ADC_RIGHT) begin
          dist_r[1] <= {6'd0, adc_r};
        end else if (chan_r == ADC_VOLT) begin
          volt_r <= {4'd0, volt_prod[19:8]};
        end
      end
    end
  end

  // Result register: load on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      rd_r     <= rd_nxt;
      ack_r    <= ack_nxt;
      brst_r   <= brst_nxt;
      trig_r   <= trig_nxt;
      reboot_r <= reboot_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_read_data       = rd_r;
  assign out_ack             = ack_r;
  assign out_bus_reset       = brst_r;
  assign out_trigger_channel = trig_r;
  assign out_reboot_request  = reboot_r;

  `ISRS_ASSERT_NOW(a_reboot_nak, out_vld_r && reboot_r, !ack_r, "reboot result was acked")
  `ISRS_ASSERT_NOW(a_trig_ack, out_vld_r && (trig_r != TRIG_NONE), ack_r,
    "trigger without ack")
  `ISRS_ASSERT_NOW(a_brst_clean, out_vld_r && brst_r,
    (rd_r == 8'd0) && (trig_r == TRIG_NONE) && !reboot_r, "bus reset result not clean")
  `ISRS_ASSERT_NEXT(a_req_held, in_vld_r && !out_free, in_vld_r && $stable(kind_r),
    "stalled request lost")

endmodule

`default_nettype wire
